FILE: rtl/assert_macros.svh
// Assertion macros shared by the record slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rst_pkg.sv
// Types and constants of the record slot table.
`timescale 1ns / 1ps
`default_nettype none

package rst_pkg;

  localparam int DEF_SLOTS = 8;
  localparam int MAX_LIST  = 8;
  localparam int ID_W      = 31;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_MISS,
    S_SCAN,
    S_HIT,
    S_LIST
  } state_t;

  // One stored record as it sits in the slot memory.
  typedef struct packed {
    logic [31:0]     salary;
    logic [63:0]     name2;
    logic [63:0]     name1;
    logic [63:0]     name0;
    logic [ID_W-1:0] id;
  } rec_t;

endpackage

`default_nettype wire

FILE: rtl/rst_mem.sv
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rst_mem #(
  parameter int SLOTS = rst_pkg::DEF_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  wire rst_pkg::rec_t              wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]   rd_addr,
  output rst_pkg::rec_t                   rd_data
);
  import rst_pkg::*;

  rec_t mem [SLOTS];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read data while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/rst_ctrl.sv
// Operation sequencer: slot valid bits, identifier counter, memory scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module rst_ctrl #(
  parameter int SLOTS = rst_pkg::DEF_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rst_pkg::kind_t             in_kind,
  input  wire logic [rst_pkg::ID_W-1:0]   in_key,
  input  wire rst_pkg::rec_t              in_rec,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rst_pkg::status_t                out_status,
  output logic [2:0]                      out_slot,
  output rst_pkg::rec_t                   out_rec,
  output logic                            out_last,
  output logic                            mem_wr_en,
  output logic [$clog2(SLOTS)-1:0]        mem_wr_addr,
  output rst_pkg::rec_t                   mem_wr_data,
  output logic                            mem_rd_en,
  output logic [$clog2(SLOTS)-1:0]        mem_rd_addr,
  input  wire rst_pkg::rec_t              mem_rd_data
);
  import rst_pkg::*;

  localparam int IW = $clog2(SLOTS);

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  rec_t              wrec_r, wrec_nxt;
  status_t           miss_st_r, miss_st_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              rd_more_r, rd_more_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [2:0]        lcnt_r, lcnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [2:0]        out_slot_r, out_slot_nxt;
  rec_t              out_rec_r, out_rec_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              free_any;
  logic [IW-1:0]     free_idx;
  logic [SLOTS-1:0]  above;
  logic              chk_last;
  logic              hit;
  logic              list_need;
  logic              list_last;
  rec_t              ins_rec;

  assign out_free = !out_valid_r || out_ready;
  assign free_any = !(&valid_r);
  assign chk_last = (chk_idx_r == IW'(SLOTS - 1));
  assign hit      = chk_vld_r && valid_r[chk_idx_r] && (mem_rd_data.id == key_r);
  assign list_need = chk_vld_r && valid_r[chk_idx_r];
  assign list_last = (lcnt_r == 3'(MAX_LIST - 1)) || !(|above);

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      above[i] = valid_r[i] && (IW'(i) > chk_idx_r);
    end
  end

  always_comb begin
    ins_rec    = wrec_r;
    ins_rec.id = next_id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      rd_more_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      rd_more_r   <= rd_more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    wrec_r     <= wrec_nxt;
    miss_st_r  <= miss_st_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    lcnt_r     <= lcnt_nxt;
    out_st_r   <= out_st_nxt;
    out_slot_r <= out_slot_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    logic       emit;
    status_t    e_st;
    logic [2:0] e_slot;
    rec_t       e_rec;
    logic       e_last;
    logic       issue;
    logic       hold;

    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    wrec_nxt    = wrec_r;
    miss_st_nxt = miss_st_r;
    valid_nxt   = valid_r;
    next_id_nxt = next_id_r;
    rd_idx_nxt  = rd_idx_r;
    rd_more_nxt = rd_more_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    lcnt_nxt    = lcnt_r;

    in_ready    = (state_r == S_IDLE);
    mem_wr_en   = 1'b0;
    mem_wr_addr = free_idx;
    mem_wr_data = ins_rec;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx_r;

    emit   = 1'b0;
    e_st   = ST_OK;
    e_slot = 3'(chk_idx_r);
    e_rec  = mem_rd_data;
    e_last = 1'b1;
    issue  = 1'b0;
    hold   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          key_nxt     = in_key;
          wrec_nxt    = in_rec;
          rd_idx_nxt  = '0;
          rd_more_nxt = 1'b1;
          chk_vld_nxt = 1'b0;
          lcnt_nxt    = '0;
          case (in_kind)
            KIND_INSERT: begin
              if (free_any) begin
                state_nxt = S_INSERT;
              end else begin
                miss_st_nxt = ST_FULL;
                state_nxt   = S_MISS;
              end
            end
            KIND_LOOKUP, KIND_REMOVE: begin
              // Identifier zero is never assigned to a record and never matches.
              if (in_key == '0) begin
                miss_st_nxt = ST_NOT_FOUND;
                state_nxt   = S_MISS;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_LIST: begin
              if (valid_r == '0) begin
                miss_st_nxt = ST_EMPTY;
                state_nxt   = S_MISS;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (out_free) begin
          mem_wr_en           = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          emit                = 1'b1;
          e_slot              = 3'(free_idx);
          e_rec               = ins_rec;
          // Wrap the identifier back to one, skipping zero.
          next_id_nxt = (next_id_r == ID_MAX) ? ID_W'(1) : next_id_r + ID_W'(1);
          state_nxt   = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          emit      = 1'b1;
          e_st      = miss_st_r;
          e_slot    = '0;
          e_rec     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_HIT;
        end else begin
          issue = rd_more_r;
          if (chk_vld_r && chk_last) begin
            miss_st_nxt = ST_NOT_FOUND;
            state_nxt   = S_MISS;
          end
        end
      end
      S_HIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (kind_r == KIND_REMOVE) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        // Stall the scan while a listed slot waits for the result register.
        hold = list_need && !out_free;
        if (!hold) begin
          if (list_need) begin
            emit     = 1'b1;
            e_last   = list_last;
            lcnt_nxt = lcnt_r + 3'd1;
          end
          if ((list_need && list_last) || (chk_vld_r && chk_last)) begin
            state_nxt = S_IDLE;
          end else begin
            issue = rd_more_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_SCAN || state_r == S_LIST) begin
      // Keep the pending slot check while the scan is held.
      if (state_nxt == state_r && !hold) begin
        chk_vld_nxt = issue;
      end
      if (issue) begin
        mem_rd_en   = 1'b1;
        chk_idx_nxt = rd_idx_r;
        if (rd_idx_r == IW'(SLOTS - 1)) begin
          rd_more_nxt = 1'b0;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
    end

    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_slot_nxt  = out_slot_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = e_st;
      out_slot_nxt  = e_slot;
      out_rec_nxt   = e_rec;
      out_last_nxt  = e_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_slot   = out_slot_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_id_nonzero, next_id_r != '0, "next identifier reached zero")
  `ASSERT_IMPL(a_wr_free, mem_wr_en, !valid_r[mem_wr_addr], "insert overwrites a valid slot")
  `ASSERT_IMPL(a_hit_valid, state_r == S_HIT, valid_r[chk_idx_r], "hit on a free slot")
  `ASSERT_NEXT(a_remove_clears, state_r == S_HIT && out_free && kind_r == KIND_REMOVE, !valid_r[$past(chk_idx_r)], "removed slot still valid")

endmodule

`default_nettype wire

FILE: rtl/record_slot_table_unit.sv
// Top level of the record slot table: stream ports, slot memory and sequencer.
// Record slot table with SLOTS entries. Each input transfer (kind in in_tuser) is
// an insert, lookup, remove or list. An insert writes a free slot and loads its
// result into the result register. Lookup and remove scan the slot memory one
// entry per cycle through its single read port; list scans the same way while the
// output is not stalled and emits up to eight results, one per valid slot. A new
// item is accepted only once the previous one has produced all its results; the
// result register lets the next item be taken while the last result still waits.
// Status travels in out_tuser, the final result of an item carries out_tlast. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module record_slot_table_unit #(
  parameter int SLOTS = rst_pkg::DEF_SLOTS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // kind
  input  wire logic [1:0]   in_tuser,
  // key_id, name_word0, name_word1, name_word2, salary_bits, zero pad
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status
  output logic [1:0]        out_tuser,
  // slot_index, record_id, out_name0, out_name1, out_name2, out_salary, zero pad
  output logic [263:0]      out_tdata,
  output logic              out_tlast
);
  import rst_pkg::*;

  localparam int IW = $clog2(SLOTS);

  rec_t            in_rec;
  rec_t            out_rec;
  status_t         out_status;
  logic [2:0]      out_slot;
  logic            mem_wr_en;
  logic [IW-1:0]   mem_wr_addr;
  rec_t            mem_wr_data;
  logic            mem_rd_en;
  logic [IW-1:0]   mem_rd_addr;
  rec_t            mem_rd_data;

  always_comb begin
    in_rec.id     = in_tdata[30:0];
    in_rec.name0  = in_tdata[94:31];
    in_rec.name1  = in_tdata[158:95];
    in_rec.name2  = in_tdata[222:159];
    in_rec.salary = in_tdata[254:223];
  end

  rst_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (kind_t'(in_tuser)),
    .in_key     (in_tdata[30:0]),
    .in_rec     (in_rec),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_rec    (out_rec),
    .out_last   (out_tlast),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  rst_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign out_tuser = out_status;
  assign out_tdata = {6'd0, out_rec.salary, out_rec.name2, out_rec.name1,
                      out_rec.name0, out_rec.id, out_slot};

endmodule

`default_nettype wire
